>>> sv/region_pose_energy_and_gradient_core_assert.svh
// ---------------------------------------------------------------------------
// Region pose energy core assertion macros
// Short forms for concurrent checks clocked on clk with async reset rst_n.
// ---------------------------------------------------------------------------
`ifndef REGION_POSE_ENERGY_AND_GRADIENT_CORE_ASSERT_SVH
`define REGION_POSE_ENERGY_AND_GRADIENT_CORE_ASSERT_SVH

// Same-cycle implication
`define RPEG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RPEG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/rpeg_pkg.sv
// ---------------------------------------------------------------------------
// Region pose energy package
// Fixed-point constants and sequencer state type for the region energy core.
// ---------------------------------------------------------------------------
package rpeg_pkg;

    // Probability format Q1.16, one = 1 << PROB_FRAC_BITS
    localparam int PROB_FRAC_BITS = 16;
    localparam logic [16:0] PROB_ONE = 17'h10000;

    // Log and constant scale factors
    localparam int FRAC_LOG = 20;
    localparam logic [25:0] LOG_TOP = 26'(2 * PROB_FRAC_BITS) << FRAC_LOG;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
    localparam logic [16:0] GRAD_SCALE = 17'd122880;
    localparam logic [35:0] DIRAC_BIAS = 36'd102400;

    // Saturation limits and special values
    localparam logic [23:0] E24_MAX = 24'hFFFFFF;
    localparam logic [31:0] GRAD_POS_LIM = 32'h7FFFFFFF;
    localparam logic [31:0] GRAD_NEG_LIM = 32'h80000000;
    localparam logic [31:0] GRAD_OUT_BAND = 32'hFFFF0000;

    // Widths
    localparam int DIV_W = 134;
    localparam int DEN_W = 101;
    localparam int MUL_W = 36;
    localparam int SQ_STEPS = 20;
    localparam int GRAD_QBITS = 32;
    localparam int MEAN_QBITS = 24;
    localparam int OUT_TDATA_W = 104;
    localparam int IN_TDATA_W = 56;

    typedef enum logic [15:0] {
        ST_IDLE = 16'h0001,
        ST_HP   = 16'h0002,
        ST_QQ   = 16'h0004,
        ST_D2   = 16'h0008,
        ST_NORM = 16'h0010,
        ST_SQ   = 16'h0020,
        ST_LN   = 16'h0040,
        ST_PA   = 16'h0080,
        ST_PL   = 16'h0100,
        ST_PH   = 16'h0200,
        ST_NM   = 16'h0400,
        ST_GDIV = 16'h0800,
        ST_ACC  = 16'h1000,
        ST_LAST = 16'h2000,
        ST_MDIV = 16'h4000,
        ST_DONE = 16'h8000
    } state_t;

endpackage

>>> sv/region_pose_energy_and_gradient_core.sv
// ---------------------------------------------------------------------------
// Region pose energy and gradient core
// Per-pixel region energy, gradient term and per-region mean energy.
// ---------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per request: contour distance, Heaviside level
//   and foreground probability in tdata, last pixel of the region in tlast.
//   m_axis returns one result per pixel; tlast marks the region's last one.
//   cfg writes band_width; write it only while the core is idle.
// Sequence:
//   Out-of-band pixel: skips the energy and gradient arithmetic.
//   In-band pixel: 3 multiplies, normalize shifts, 20 squarings, a log
//   scale, 4 gradient multiplies and a restoring divide; a balanced
//   probability skips the gradient and a zero energy argument skips
//   the log and gradient. A last pixel with a nonzero count adds a mean
//   divide. One shared 36x36 multiplier and one 134-bit subtract/compare
//   unit serve these steps; s_axis_tready is high only while the sequencer
//   is idle, so a new pixel is taken only once the last one is done.
// Reset:
//   band_width returns to 10, accumulators clear, no result is pending.
// Stall:
//   A result waits in the output register; the next pixel is still taken and
//   computed, and its result holds until the output register frees up.
// ---------------------------------------------------------------------------
`include "region_pose_energy_and_gradient_core_assert.svh"

module region_pose_energy_and_gradient_core
    import rpeg_pkg::*;
#(
    parameter int COUNT_BITS = 22
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration write: band_width
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [8:0]             cfg_data,
    // tdata: contour_distance[15:0], heaviside_level[32:16],
    //        fg_probability[49:33], zero pad[55:50]
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   s_axis_tlast,
    // tdata: in_band[0], pixel_energy[24:1], gradient_term[56:25],
    //        mean_energy[80:57], band_count[102:81], zero pad[103]
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tlast
);

    // Control state
    state_t                 state_reg, state_next;
    logic [8:0]             bw_reg, bw_next;
    logic [47:0]            total_reg, total_next;
    logic [COUNT_BITS-1:0]  tally_reg, tally_next;
    logic                   ovalid_reg, ovalid_next;

    // Payload state
    logic [16:0]            h_reg, h_next;
    logic [16:0]            p_reg, p_next;
    logic [16:0]            dmag_reg, dmag_next;
    logic                   last_reg, last_next;
    logic                   inb_reg, inb_next;
    logic                   neg_reg, neg_next;
    logic [16:0]            nmag_reg, nmag_next;
    logic [32:0]            a_reg, a_next;
    logic [35:0]            x_reg, x_next;
    logic [32:0]            nx_reg, nx_next;
    logic [25:0]            lg_reg, lg_next;
    logic [31:0]            m_reg, m_next;
    logic [4:0]             it_reg, it_next;
    logic [63:0]            pa_reg, pa_next;
    logic [DEN_W-1:0]       d_reg, d_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;
    logic [DIV_W-1:0]       dd_reg, dd_next;
    logic [32:0]            q_reg, q_next;
    logic [5:0]             cnt_reg, cnt_next;
    logic [23:0]            energy_reg, energy_next;
    logic [31:0]            grad_reg, grad_next;
    logic [23:0]            mean_reg, mean_next;
    logic [21:0]            bcount_reg, bcount_next;
    logic [OUT_TDATA_W-1:0] odata_reg, odata_next;
    logic                   olast_reg, olast_next;

    // Shared multiplier
    logic [MUL_W-1:0]       mul_a, mul_b;
    logic [2*MUL_W-1:0]     prod;

    // Shared divide step
    logic                   div_ge;
    logic [DIV_W-1:0]       div_rem;
    logic [32:0]            div_q;

    // Input decode
    logic [15:0]            in_dist;
    logic [16:0]            in_h, in_p, in_hc, in_pc, in_dmag;
    logic [17:0]            in_p2;
    logic                   in_neg;
    logic [16:0]            in_nmag;
    logic                   in_inb;

    // Misc datapath
    logic [32:0]            sq_t;
    logic [25:0]            ln_l;
    logic [58:0]            ln_sum;
    logic [31:0]            g_lim, g_mag;
    logic [48:0]            acc_sum;
    logic [COUNT_BITS-1:0]  tally_max;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;
    assign m_axis_tlast  = olast_reg;

    assign tally_max = '1;

    // Decode and clamp the incoming pixel
    always_comb
    begin
        in_dist = s_axis_tdata[15:0];
        in_h    = s_axis_tdata[32:16];
        in_p    = s_axis_tdata[49:33];
        in_hc   = (in_h > PROB_ONE) ? PROB_ONE : in_h;
        in_pc   = (in_p > PROB_ONE) ? PROB_ONE : in_p;
        in_dmag = in_dist[15] ? (17'h10000 - {1'b0, in_dist}) : {1'b0, in_dist};
        in_inb  = (in_dmag <= {2'b00, bw_reg, 6'b000000});
        in_p2   = {in_pc, 1'b0};
        in_neg  = (in_p2 < {1'b0, PROB_ONE});
        in_nmag = in_neg ? 17'({1'b0, PROB_ONE} - in_p2) : 17'(in_p2 - {1'b0, PROB_ONE});
    end

    // Select multiplier operands by step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_HP:
            begin
                mul_a = 36'(h_reg);
                mul_b = 36'(p_reg);
            end
            ST_QQ:
            begin
                mul_a = 36'(PROB_ONE - h_reg);
                mul_b = 36'(PROB_ONE - p_reg);
            end
            ST_D2:
            begin
                mul_a = 36'(dmag_reg);
                mul_b = 36'(dmag_reg);
            end
            ST_SQ:
            begin
                mul_a = 36'(m_reg);
                mul_b = 36'(m_reg);
            end
            ST_LN:
            begin
                mul_a = 36'(ln_l);
                mul_b = 36'(LN2_Q32);
            end
            ST_PA:
            begin
                mul_a = 36'(PI_Q30);
                mul_b = 36'(a_reg);
            end
            ST_PL:
            begin
                mul_a = 36'(pa_reg[32:0]);
                mul_b = x_reg;
            end
            ST_PH:
            begin
                mul_a = 36'(pa_reg[63:33]);
                mul_b = x_reg;
            end
            ST_NM:
            begin
                mul_a = 36'(nmag_reg);
                mul_b = 36'(GRAD_SCALE);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // Restoring divide step, one quotient bit per cycle
    always_comb
    begin
        div_ge  = (rem_reg >= dd_reg);
        div_rem = div_ge ? (rem_reg - dd_reg) : rem_reg;
        div_q   = {q_reg[31:0], div_ge};
    end

    // Helper terms for log, gradient and accumulate steps
    always_comb
    begin
        sq_t    = prod[63:31];
        ln_l    = LOG_TOP - lg_reg;
        ln_sum  = 59'(prod[57:0]) + (59'(1) << 35);
        g_lim   = neg_reg ? GRAD_NEG_LIM : GRAD_POS_LIM;
        g_mag   = (div_q[32] || (div_q[31:0] > g_lim)) ? g_lim : div_q[31:0];
        acc_sum = {1'b0, total_reg} + 49'(energy_reg);
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        bw_next     = bw_reg;
        total_next  = total_reg;
        tally_next  = tally_reg;
        ovalid_next = ovalid_reg;
        h_next      = h_reg;
        p_next      = p_reg;
        dmag_next   = dmag_reg;
        last_next   = last_reg;
        inb_next    = inb_reg;
        neg_next    = neg_reg;
        nmag_next   = nmag_reg;
        a_next      = a_reg;
        x_next      = x_reg;
        nx_next     = nx_reg;
        lg_next     = lg_reg;
        m_next      = m_reg;
        it_next     = it_reg;
        pa_next     = pa_reg;
        d_next      = d_reg;
        rem_next    = rem_reg;
        dd_next     = dd_reg;
        q_next      = q_reg;
        cnt_next    = cnt_reg;
        energy_next = energy_reg;
        grad_next   = grad_reg;
        mean_next   = mean_reg;
        bcount_next = bcount_reg;
        odata_next  = odata_reg;
        olast_next  = olast_reg;

        // Take configuration writes at any time
        if (cfg_valid)
        begin
            bw_next = cfg_data;
        end

        // Drop the output once the receiver takes it
        if (ovalid_reg && m_axis_tready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    h_next    = in_hc;
                    p_next    = in_pc;
                    dmag_next = in_dmag;
                    last_next = s_axis_tlast;
                    inb_next  = in_inb;
                    neg_next  = in_neg;
                    nmag_next = in_nmag;
                    if (in_inb)
                    begin
                        state_next = ST_HP;
                    end
                    else
                    begin
                        energy_next = '0;
                        grad_next   = GRAD_OUT_BAND;
                        state_next  = ST_LAST;
                    end
                end
            end
            ST_HP:
            begin
                a_next     = prod[32:0];
                state_next = ST_QQ;
            end
            ST_QQ:
            begin
                a_next     = a_reg + prod[32:0];
                state_next = ST_D2;
            end
            ST_D2:
            begin
                x_next = (36'(prod[30:0]) << 5) + (36'(prod[30:0]) << 2) + DIRAC_BIAS;
                if (a_reg == '0)
                begin
                    energy_next = E24_MAX;
                    grad_next   = (nmag_reg == '0) ? '0 :
                                  (neg_reg ? GRAD_NEG_LIM : GRAD_POS_LIM);
                    state_next  = ST_ACC;
                end
                else
                begin
                    nx_next    = a_reg;
                    lg_next    = 26'd32;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                // Shift until the leading one reaches the top bit
                if (nx_reg[32])
                begin
                    m_next     = nx_reg[32:1];
                    it_next    = '0;
                    state_next = ST_SQ;
                end
                else
                begin
                    nx_next = {nx_reg[31:0], 1'b0};
                    lg_next = lg_reg - 26'd1;
                end
            end
            ST_SQ:
            begin
                // One log2 fraction bit per squaring
                if (sq_t[32])
                begin
                    m_next  = sq_t[32:1];
                    lg_next = {lg_reg[24:0], 1'b1};
                end
                else
                begin
                    m_next  = sq_t[31:0];
                    lg_next = {lg_reg[24:0], 1'b0};
                end
                it_next = it_reg + 5'd1;
                if (it_reg == 5'(SQ_STEPS - 1))
                begin
                    state_next = ST_LN;
                end
            end
            ST_LN:
            begin
                energy_next = 24'(ln_sum[58:36]);
                if (nmag_reg == '0)
                begin
                    grad_next  = '0;
                    state_next = ST_ACC;
                end
                else
                begin
                    state_next = ST_PA;
                end
            end
            ST_PA:
            begin
                pa_next    = prod[63:0];
                state_next = ST_PL;
            end
            ST_PL:
            begin
                d_next     = DEN_W'(prod[68:0]);
                state_next = ST_PH;
            end
            ST_PH:
            begin
                d_next     = d_reg + (DEN_W'(prod[66:0]) << 33);
                state_next = ST_NM;
            end
            ST_NM:
            begin
                rem_next   = DIV_W'(prod[33:0]) << 62;
                dd_next    = DIV_W'(d_reg) << GRAD_QBITS;
                q_next     = '0;
                cnt_next   = 6'(GRAD_QBITS);
                state_next = ST_GDIV;
            end
            ST_GDIV:
            begin
                rem_next = div_rem;
                dd_next  = dd_reg >> 1;
                q_next   = div_q;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    grad_next  = neg_reg ? (32'd0 - g_mag) : g_mag;
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                total_next = acc_sum[48] ? '1 : acc_sum[47:0];
                if (tally_reg != tally_max)
                begin
                    tally_next = tally_reg + 1'b1;
                end
                state_next = ST_LAST;
            end
            ST_LAST:
            begin
                bcount_next = 22'(tally_reg);
                if (!last_reg)
                begin
                    mean_next  = '0;
                    state_next = ST_DONE;
                end
                else if (tally_reg == '0)
                begin
                    mean_next  = E24_MAX;
                    total_next = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    rem_next   = DIV_W'(total_reg);
                    dd_next    = DIV_W'(tally_reg) << MEAN_QBITS;
                    q_next     = '0;
                    cnt_next   = 6'(MEAN_QBITS);
                    state_next = ST_MDIV;
                end
            end
            ST_MDIV:
            begin
                rem_next = div_rem;
                dd_next  = dd_reg >> 1;
                q_next   = div_q;
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    mean_next  = div_q[24] ? E24_MAX : div_q[23:0];
                    total_next = '0;
                    tally_next = '0;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register is free
                if (!ovalid_reg || m_axis_tready)
                begin
                    odata_next  = {1'b0, bcount_reg, mean_reg, grad_reg, energy_reg, inb_reg};
                    olast_next  = last_reg;
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            bw_reg     <= 9'd10;
            total_reg  <= '0;
            tally_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bw_reg     <= bw_next;
            total_reg  <= total_next;
            tally_reg  <= tally_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        h_reg      <= h_next;
        p_reg      <= p_next;
        dmag_reg   <= dmag_next;
        last_reg   <= last_next;
        inb_reg    <= inb_next;
        neg_reg    <= neg_next;
        nmag_reg   <= nmag_next;
        a_reg      <= a_next;
        x_reg      <= x_next;
        nx_reg     <= nx_next;
        lg_reg     <= lg_next;
        m_reg      <= m_next;
        it_reg     <= it_next;
        pa_reg     <= pa_next;
        d_reg      <= d_next;
        rem_reg    <= rem_next;
        dd_reg     <= dd_next;
        q_reg      <= q_next;
        cnt_reg    <= cnt_next;
        energy_reg <= energy_next;
        grad_reg   <= grad_next;
        mean_reg   <= mean_next;
        bcount_reg <= bcount_next;
        odata_reg  <= odata_next;
        olast_reg  <= olast_next;
    end

    // Checks
    `RPEG_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready,
        !s_axis_tready, "core took a pixel while still busy")
    `RPEG_ASSERT_NOW(a_out_band_values, m_axis_tvalid && !m_axis_tdata[0],
        m_axis_tdata[24:1] == '0 && m_axis_tdata[56:25] == GRAD_OUT_BAND,
        "out-of-band result carries wrong energy or gradient")
    `RPEG_ASSERT_NOW(a_mean_only_last, m_axis_tvalid && !m_axis_tlast,
        m_axis_tdata[80:57] == '0, "mean energy set on a non-last result")
    `RPEG_ASSERT_NOW(a_div_count, state_reg == ST_GDIV || state_reg == ST_MDIV,
        cnt_reg <= 6'(GRAD_QBITS), "divide step count out of range")

endmodule
